### rtl/sfc_pkg.sv
package sfc_pkg;

  // Default payload store depth
  localparam int MAX_PAYLOAD_DEF = 32;

  // Beat widths
  localparam int RX_W   = 8;
  localparam int OUT_W  = 16;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_ON_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_OFF_CODE = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_MARKER_RST = 8'h53;
  localparam logic [7:0] LED_ON_CODE_RST  = 8'h01;
  localparam logic [7:0] LED_OFF_CODE_RST = 8'h02;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY_OK = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

  // Payload index that carries the indicator command
  localparam int CMD_POS = 3;

endpackage

### rtl/serial_frame_checker_unit.sv
// Channel   | Dir | Beat contents (lowest bit first)
// ----------+-----+--------------------------------------------------------
// s_axis    | in  | tdata: rx_byte[7:0]
// m_axis    | out | tdata: payload_byte[7:0], led_state[8], zeros[15:9];
//           |     | tuser: status[1:0]; tlast: last_of_frame
// cfg       | in  | cfg_index: register index, cfg_data: value; always ready
//
// Bytes are taken back to back while receiving. After a good check byte the
// stored payload replays through the single store read port, each result by
// a registered read, then an output load; input is held off until the last
// one is loaded. Empty, mismatch and too-long frames give one result in the
// cycle after the check byte. rst is synchronous and clears control, config
// and the indicator; the payload store is not cleared. An output stall holds
// the result; bytes other than the check byte are still taken meanwhile.
module serial_frame_checker_unit #(
  parameter int MAX_PAYLOAD = sfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // rx_byte[7:0]
  input  logic [sfc_pkg::RX_W-1:0]      s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // payload_byte[7:0], led_state[8], zero fill [15:9]
  output logic [sfc_pkg::OUT_W-1:0]     m_tdata,
  // status[1:0]
  output logic [sfc_pkg::STAT_W-1:0]    m_tuser,
  output logic                          m_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import sfc_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEN   = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;

  logic [2:0]       state;
  logic [7:0]       start_marker;
  logic [7:0]       led_on_code;
  logic [7:0]       led_off_code;
  logic [7:0]       frame_length;
  logic [7:0]       byte_index;
  logic [7:0]       running_sum;
  logic [7:0]       cmd_byte;
  logic             indicator;
  logic [IDX_W-1:0] play_idx;
  logic [7:0]       rd_data;
  logic [7:0]       store [MAX_PAYLOAD];

  logic [7:0]        out_byte;
  logic              out_led;
  logic [STAT_W-1:0] out_status;
  logic              out_last;
  logic              out_valid;

  logic       in_fire;
  logic       out_free;
  logic       len_ok;
  logic [7:0] expect_sum;
  logic [7:0] index_next;
  logic [7:0] play_count;
  logic       play_last;
  logic       cmd_on;
  logic       cmd_off;

  assign out_free   = !out_valid || m_tready;
  assign s_tready   = (state == S_IDLE) || (state == S_LEN) || (state == S_DATA) ||
                      ((state == S_CHECK) && out_free);
  assign in_fire    = s_tvalid && s_tready;
  assign len_ok     = frame_length <= MAX_LEN;
  assign expect_sum = ~running_sum + 8'd1;
  assign index_next = byte_index + 8'd1;
  assign play_count = {{(8-IDX_W){1'b0}}, play_idx} + 8'd1;
  assign play_last  = play_count == frame_length;
  assign cmd_on     = cmd_byte == led_on_code;
  assign cmd_off    = cmd_byte == led_off_code;
  assign cfg_ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      led_on_code  <= LED_ON_CODE_RST;
      led_off_code <= LED_OFF_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_data;
        REG_LED_ON_CODE:  led_on_code  <= cfg_data;
        REG_LED_OFF_CODE: led_off_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload store: write while receiving, registered read for replay
  always_ff @(posedge clk) begin
    if (in_fire && (state == S_DATA) && len_ok) begin
      store[byte_index[IDX_W-1:0]] <= s_tdata;
    end
    rd_data <= store[play_idx];
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_length <= '0;
      byte_index   <= '0;
      running_sum  <= '0;
      indicator    <= 1'b0;
      play_idx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && (s_tdata == start_marker)) state <= S_LEN;
        end
        S_LEN: begin
          if (in_fire) begin
            frame_length <= s_tdata;
            byte_index   <= '0;
            running_sum  <= '0;
            state        <= (s_tdata == 8'd0) ? S_CHECK : S_DATA;
          end
        end
        S_DATA: begin
          if (in_fire) begin
            running_sum <= running_sum + s_tdata;
            byte_index  <= index_next;
            if (index_next >= frame_length) state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (in_fire) begin
            state    <= S_IDLE;
            play_idx <= '0;
            if (len_ok && (s_tdata == expect_sum) && (frame_length != 8'd0)) begin
              state <= S_READ;
              if (frame_length > 8'(CMD_POS)) begin
                if (cmd_on) indicator <= 1'b1;
                else if (cmd_off) indicator <= 1'b0;
              end
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            if (play_last) begin
              state <= S_IDLE;
            end else begin
              play_idx <= play_idx + 1'b1;
              state    <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Indicator command byte, captured as it arrives
  always_ff @(posedge clk) begin
    if (in_fire && (state == S_DATA) && (byte_index == 8'(CMD_POS))) begin
      cmd_byte <= s_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (m_tready) out_valid <= 1'b0;
      if (in_fire && (state == S_CHECK)) begin
        if (!len_ok) begin
          out_valid <= 1'b1;
        end else if (s_tdata != expect_sum) begin
          out_valid <= 1'b1;
        end else if (frame_length == 8'd0) begin
          out_valid <= 1'b1;
        end
      end
      if ((state == S_LOAD) && out_free) out_valid <= 1'b1;
    end
  end

  // Output payload fields
  always_ff @(posedge clk) begin
    if (in_fire && (state == S_CHECK)) begin
      out_byte <= '0;
      out_led  <= indicator;
      out_last <= 1'b1;
      if (!len_ok) out_status <= ST_TOO_LONG;
      else if (s_tdata != expect_sum) out_status <= ST_BAD_SUM;
      else out_status <= ST_EMPTY_OK;
    end else if ((state == S_LOAD) && out_free) begin
      out_byte   <= rd_data;
      out_led    <= indicator;
      out_last   <= play_last;
      out_status <= ST_PAYLOAD;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W-9){1'b0}}, out_led, out_byte};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  // A check byte always leads to a result or to the replay sequence
  a_check_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (state == S_CHECK)) |=> (m_tvalid || (state == S_READ)))
    else $error("check byte gave neither a result nor a replay");

  // Replay never reads past the received length
  a_play_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (play_count <= frame_length) && len_ok)
    else $error("replay index beyond frame length");

  // The indicator only moves on an accepted check byte or on reset
  a_led_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(indicator) |-> ($past(rst) || $past(in_fire && (state == S_CHECK))))
    else $error("indicator changed outside frame completion");
`endif

endmodule

### test/sfc_result_checker.sv
`timescale 1ns / 100ps

// Watches the byte, result and register channels of the frame checker,
// predicts the result beats from the accepted bytes and compares them in order.
module sfc_result_checker #(
  parameter int MAX_PAYLOAD = sfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sfc_pkg::RX_W-1:0]      s_tdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [sfc_pkg::OUT_W-1:0]     m_tdata,
  input  logic [sfc_pkg::STAT_W-1:0]    m_tuser,
  input  logic                          m_tlast,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            fail_count,
  output int                            pending,
  output bit                            frame_open
);
  import sfc_pkg::*;

  typedef enum logic [1:0] {RX_IDLE, RX_LEN, RX_DATA, RX_CHECK} rx_phase_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [7:0]        payload;
    logic              last;
    logic              led;
  } result_beat_t;

  // Register copies
  logic [7:0] marker_reg;
  logic [7:0] on_code_reg;
  logic [7:0] off_code_reg;

  // Deframer state
  rx_phase_t  rx_phase;
  logic [7:0] frame_len;
  logic [7:0] rx_count;
  logic [7:0] csum;
  logic [7:0] frame_buf [MAX_PAYLOAD];
  logic       led;

  // Predicted result beats, oldest first
  result_beat_t replay_q[$];

  task automatic push_beat(input logic [STAT_W-1:0] st, input logic [7:0] pb,
                           input logic last);
    result_beat_t beat;
    beat.status  = st;
    beat.payload = pb;
    beat.last    = last;
    beat.led     = led;
    replay_q.push_back(beat);
  endtask

  // Check byte: verdict, indicator command, then replay of the stored payload
  task automatic finish_frame(input logic [7:0] chk);
    logic [7:0] want_chk;
    int         i;
    want_chk = 8'h00 - csum;
    rx_phase = RX_IDLE;
    if (frame_len > MAX_PAYLOAD) begin
      push_beat(ST_TOO_LONG, 8'h00, 1'b1);
    end else if (chk != want_chk) begin
      push_beat(ST_BAD_SUM, 8'h00, 1'b1);
    end else if (frame_len == 8'h00) begin
      push_beat(ST_EMPTY_OK, 8'h00, 1'b1);
    end else begin
      // short frames leave the indicator alone; on wins over off
      if (frame_len > CMD_POS) begin
        if (frame_buf[CMD_POS] == on_code_reg) begin
          led = 1'b1;
        end else if (frame_buf[CMD_POS] == off_code_reg) begin
          led = 1'b0;
        end
      end
      for (i = 0; i < frame_len; i++) begin
        push_beat(ST_PAYLOAD, frame_buf[i], (i + 1 == frame_len));
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    case (rx_phase)
      RX_IDLE: begin
        if (b == marker_reg) rx_phase = RX_LEN;
      end
      RX_LEN: begin
        frame_len = b;
        rx_count  = 8'h00;
        csum      = 8'h00;
        rx_phase  = (b == 8'h00) ? RX_CHECK : RX_DATA;
      end
      RX_DATA: begin
        // oversize frames are summed and counted but never stored
        if (frame_len <= MAX_PAYLOAD) frame_buf[rx_count] = b;
        csum     = csum + b;
        rx_count = rx_count + 8'd1;
        if (rx_count >= frame_len) rx_phase = RX_CHECK;
      end
      default: begin
        finish_frame(b);
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    if (rst) begin
      marker_reg   = START_MARKER_RST;
      on_code_reg  = LED_ON_CODE_RST;
      off_code_reg = LED_OFF_CODE_RST;
      rx_phase     = RX_IDLE;
      frame_len    = 8'h00;
      rx_count     = 8'h00;
      csum         = 8'h00;
      led          = 1'b0;
      fail_count   = 0;
      replay_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_MARKER: marker_reg   = cfg_data;
          REG_LED_ON_CODE:  on_code_reg  = cfg_data;
          REG_LED_OFF_CODE: off_code_reg = cfg_data;
          default: ;
        endcase
      end
      // received byte beat
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      // result beat
      if (m_tvalid && m_tready) begin
        if (replay_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got tdata=%h tuser=%h tlast=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = replay_q.pop_front();
          check_field("status", 16'(want.status), 16'(m_tuser));
          check_field("payload_byte", 16'(want.payload), 16'(m_tdata[7:0]));
          check_field("last_of_frame", 16'(want.last), 16'(m_tlast));
          check_field("led_state", 16'(want.led), 16'(m_tdata[8]));
          check_field("tdata fill", 16'h0000, 16'(m_tdata[15:9]));
        end
      end
    end
    pending    = replay_q.size();
    frame_open = (rx_phase != RX_IDLE);
  end

endmodule

### test/serial_frame_checker_unit_tb.sv
`timescale 1ns / 100ps

module serial_frame_checker_unit_tb;
  import sfc_pkg::*;

  localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;

  typedef enum {CMD_RANDOM, CMD_ON, CMD_OFF, CMD_NONE} cmd_sel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [RX_W-1:0]      s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic [STAT_W-1:0]    m_tuser;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int fail_count;
  int pending;
  bit frame_open;

  // stimulus copies of the register values, used to build frames
  logic [7:0] marker_val = START_MARKER_RST;
  logic [7:0] on_val     = LED_ON_CODE_RST;
  logic [7:0] off_val    = LED_OFF_CODE_RST;

  // no idling on either side while set
  bit steady = 1'b0;

  always #4 clk = ~clk;

  serial_frame_checker_unit #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sfc_result_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) result_chk (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .frame_open(frame_open)
  );

  // Result side backpressure
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 24);
  end

  // One byte beat; valid stays high on return so back-to-back beats are legal
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  // Marker, length, payload, check byte. fill < 0 gives random payload.
  task automatic send_frame(input int len, input int fill, input cmd_sel_t cmd,
                            input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = 8'h00;
    send_byte(marker_val);
    send_byte(len[7:0]);
    for (i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
      if (i == CMD_POS) begin
        case (cmd)
          CMD_ON:  b = on_val;
          CMD_OFF: b = off_val;
          CMD_RANDOM: begin
            case ($urandom_range(3))
              0: b = on_val;
              1: b = off_val;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      sum = sum + b;
      send_byte(b);
    end
    b = 8'h00 - sum;
    if (bad_sum) b = b ^ 8'($urandom_range(255, 1));
    send_byte(b);
  endtask

  // Drop valid and wait for every predicted beat
  task automatic settle(input int extra);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Feed filler bytes until the deframer is back to hunting for a marker
  task automatic close_frame();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_open) begin
      send_byte(8'h00);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Register writes only while the block is quiet
  task automatic set_codes(input logic [7:0] marker, input logic [7:0] on_code,
                           input logic [7:0] off_code);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [7:0]           val [3];
    int                   k;
    idx = '{REG_START_MARKER, REG_LED_ON_CODE, REG_LED_OFF_CODE};
    val = '{marker, on_code, off_code};
    close_frame();
    settle(4);
    for (k = 0; k < 3; k++) begin
      while (!steady && $urandom_range(99) < 24) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    marker_val = marker;
    on_val     = on_code;
    off_val    = off_code;
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic random_traffic(input int n_bytes);
    int         sent;
    int         pick;
    int         len;
    int         j;
    logic [7:0] b;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(MAX_PAYLOAD, 9);
        send_frame(len, -1, CMD_RANDOM, 1'b0);
        sent += len + 3;
      end else if (pick < 75) begin
        len = $urandom_range(8);
        send_frame(len, -1, CMD_RANDOM, 1'b1);
        sent += len + 3;
      end else if (pick < 83) begin
        // stray bytes; only ignored while idle, so they are not counted
        for (j = 0; j < $urandom_range(3, 1); j++) begin
          b = 8'($urandom_range(255));
          if (b == marker_val) b = ~b;
          send_byte(b);
        end
      end else if (pick < 90) begin
        len = $urandom_range(MAX_PAYLOAD + 8, MAX_PAYLOAD + 1);
        send_frame(len, -1, CMD_RANDOM, $urandom_range(1));
        sent += len + 3;
      end else begin
        // raw noise, may open or cut into a frame
        for (j = 0; j < $urandom_range(4, 1); j++) begin
          send_byte(8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at reset register values
    send_byte(8'h00);                                   // stray bytes while idle
    send_byte(8'hFF);
    send_frame(0, -1, CMD_NONE, 1'b0);                  // empty frame accepted
    send_frame(0, -1, CMD_NONE, 1'b1);                  // empty frame, bad check
    send_frame(4, 8'hFF, CMD_ON, 1'b0);                 // indicator on
    send_frame(4, 8'h00, CMD_OFF, 1'b1);                // mismatch keeps indicator
    send_frame(3, 8'h00, CMD_NONE, 1'b0);               // short frame keeps it too
    send_frame(5, START_MARKER_RST, CMD_NONE, 1'b0);    // marker bytes as data
    send_frame(4, -1, CMD_OFF, 1'b0);                   // indicator off
    send_frame(MAX_PAYLOAD, -1, CMD_ON, 1'b0);          // full store
    send_frame(MAX_PAYLOAD + 1, -1, CMD_NONE, 1'b0);    // just too long, good sum

    // Extremes; equal command codes
    set_codes(8'h00, 8'hFF, 8'hFF);
    send_frame(4, -1, CMD_ON, 1'b0);
    send_byte(8'h01);
    random_traffic(10);

    // Other extremes, no idling on either side
    set_codes(8'hFF, 8'h00, 8'h80);
    steady = 1'b1;
    random_traffic(30);
    steady = 1'b0;

    // Random register values
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    random_traffic(8);
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    random_traffic(8);

    close_frame();
    settle(20);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
